/* rtl/core/pcc_pkg.sv */
// shared types, constants and elaboration-time helpers for the polar/cartesian converter
package pcc_pkg;

	// fixed datapath geometry
	localparam int GUARD_BITS = 2;
	localparam int DW         = 38;	// cordic x/y word, signed
	localparam int ZW         = 34;	// cordic angle word in binary turns, signed
	localparam int MAX_STEPS  = 32;

	// angle scale factors
	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
	localparam logic [30:0] TWO_PI_Q28     = 31'd1686629713;

	// quadrant bounds in binary turns
	localparam logic signed [31:0] QUARTER_TURN     = 32'sh4000_0000;
	localparam logic signed [31:0] NEG_QUARTER_TURN = -32'sh4000_0000;
	localparam logic signed [ZW-1:0] HALF_TURN      = {{(ZW-32){1'b0}}, 32'h8000_0000};
	localparam logic signed [ZW-1:0] NEG_HALF_TURN  = {{(ZW-32){1'b1}}, 32'h8000_0000};

	// result clamp values
	localparam logic [31:0] RES_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] RES_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		OP_MAG     = 2'd0,
		OP_ANGLE   = 2'd1,
		OP_POLAR_X = 2'd2,
		OP_POLAR_Y = 2'd3
	} pcc_op_t;

	// control that rides along with each item through the pipeline
	typedef struct packed {
		pcc_op_t op;
		logic    origin;
	} pcc_meta_t;

	// atan(2^-i) in binary turns
	localparam logic [31:0] ATAN_TURNS [MAX_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	// 1/K with 32 fraction bits for a given number of micro-rotations
	function automatic logic [31:0] inverse_gain(input int steps);
		logic [63:0] p;
		logic [63:0] n;
		logic [63:0] root;
		logic [63:0] bitv;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] quo;
		int i;
		// gain squared with 30 fraction bits
		p = 64'd1 << 30;
		for (i = 0; i < MAX_STEPS; i++) begin
			if (i < steps) begin
				p = p + (p >> (2 * i));
			end
		end
		// integer square root of p << 30
		n    = p << 30;
		root = '0;
		bitv = 64'd1 << 62;
		for (i = 0; i < 32; i++) begin
			if (bitv > n) begin
				bitv = bitv >> 2;
			end
		end
		for (i = 0; i < 32; i++) begin
			if (bitv != '0) begin
				if (n >= root + bitv) begin
					n    = n - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		// rounded 2^62 / k by restoring long division
		num = (64'd1 << 62) + (root >> 1);
		rem = '0;
		quo = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			quo = quo << 1;
			if (rem >= root) begin
				rem    = rem - root;
				quo[0] = 1'b1;
			end
		end
		return quo[31:0];
	endfunction

endpackage

/* rtl/core/polar_cartesian_convert.sv */
// Polar/cartesian converter: magnitude, angle, rho*cos and rho*sin by pipelined CORDIC.
// The pipeline has three setup stages, one stage per micro-rotation,
// and three stages for gain removal, rounding and clamping.
// Throughput is one transaction per cycle; the whole pipeline holds when the output
// register is full and not taken, so nothing is lost or repeated.
// arst_n clears every valid bit at once; data registers are not reset.
module polar_cartesian_convert
	import pcc_pkg::*;
#(
	parameter int CORDIC_STEPS  = 20,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,	// operand_a[31:0], operand_b[63:32]
	input  logic [1:0]  s_axis_tuser,	// opcode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,	// result[31:0]
	output logic [0:0]  m_axis_tuser	// saturated[0]
);

	localparam logic [31:0] INV_GAIN  = inverse_gain(CORDIC_STEPS);
	localparam int          ANG_SHIFT = 60 - FRACTION_BITS;
	localparam int          PW        = 63;			// theta product width
	localparam int          HIW       = DW - 16 + 32;	// gain high partial product
	localparam int          LOW       = 16 + 32;		// gain low partial product
	localparam int          AW        = ZW + 32;		// angle product width
	localparam int          RW        = HIW + 1 - 16 - GUARD_BITS;	// rounded magnitude width
	localparam logic [RW-1:0] POS_LIM = RW'(RES_MAX);
	localparam logic [RW-1:0] NEG_LIM = RW'(RES_MIN);

	logic advance;

	// input fields
	logic signed [31:0] a_in;
	logic signed [31:0] b_in;
	pcc_meta_t          meta_in;
	logic signed [PW-1:0] theta_prod;

	// stage 1: operands and theta product
	logic                 vld_s1;
	pcc_meta_t            meta_s1;
	logic signed [31:0]   a_s1;
	logic signed [31:0]   b_s1;
	logic signed [PW-1:0] prod_s1;

	// stage 2: rounded theta in turns
	logic               vld_s2;
	pcc_meta_t          meta_s2;
	logic signed [31:0] a_s2;
	logic signed [31:0] b_s2;
	logic [31:0]        tmag_s2;
	logic               tneg_s2;
	logic [PW-1:0]      tabs;
	logic [PW-1:0]      tsum;

	// cordic entry and micro-rotation stages
	logic [CORDIC_STEPS:0] vld_sc;
	pcc_meta_t             meta_sc [CORDIC_STEPS+1];
	logic signed [DW-1:0]  x_sc [CORDIC_STEPS+1];
	logic signed [DW-1:0]  y_sc [CORDIC_STEPS+1];
	logic signed [ZW-1:0]  z_sc [CORDIC_STEPS+1];
	logic signed [31:0]    zr;
	logic signed [31:0]    zf;
	logic                  far;
	logic signed [DW-1:0]  ax;
	logic signed [DW-1:0]  bx;
	logic signed [DW-1:0]  x0;
	logic signed [DW-1:0]  y0;
	logic signed [ZW-1:0]  z0;

	// stage 4: partial products
	logic                 vld_s4;
	pcc_meta_t            meta_s4;
	logic                 vneg_s4;
	logic [HIW-1:0]       hi_s4;
	logic [LOW-1:0]       lo_s4;
	logic signed [AW-1:0] ang_s4;
	logic signed [DW-1:0] vsel;
	logic [DW-1:0]        vabs;
	logic [HIW-1:0]       hi_d;
	logic [LOW-1:0]       lo_d;
	logic signed [AW-1:0] ang_d;

	// stage 5: rounded magnitude and sign
	logic          vld_s5;
	pcc_meta_t     meta_s5;
	logic          rneg_s5;
	logic [RW-1:0] rmag_s5;
	logic [HIW:0]  gsum;
	logic [AW-1:0] aabs;
	logic [AW-1:0] asum;
	logic [AW-1:0] ashr;

	// stage 6: output register
	logic          vld_s6;
	logic [31:0]   res_s6;
	logic          sat_s6;
	logic signed [RW:0] sres;

	assign advance       = ~vld_s6 | m_axis_tready;
	assign s_axis_tready = advance;

	assign a_in        = $signed(s_axis_tdata[31:0]);
	assign b_in        = $signed(s_axis_tdata[63:32]);
	assign meta_in.op  = pcc_op_t'(s_axis_tuser);
	assign meta_in.origin = (s_axis_tdata[31:0] == '0) && (s_axis_tdata[63:32] == '0);
	assign theta_prod  = b_in * $signed({1'b0, INV_TWO_PI_Q32});

	// theta magnitude rounded to turns, ties away from zero, kept to 32 bits
	assign tabs = prod_s1[PW-1] ? $unsigned(-prod_s1) : $unsigned(prod_s1);
	assign tsum = tabs + (PW'(1) << (FRACTION_BITS - 1));

	// cordic start point for both modes
	assign ax  = $signed({{(DW-32-GUARD_BITS){a_s2[31]}}, a_s2, {GUARD_BITS{1'b0}}});
	assign bx  = $signed({{(DW-32-GUARD_BITS){b_s2[31]}}, b_s2, {GUARD_BITS{1'b0}}});
	assign zr  = tneg_s2 ? -$signed(tmag_s2) : $signed(tmag_s2);
	assign zf  = $signed({~zr[31], zr[30:0]});
	assign far = (zr > QUARTER_TURN) || (zr < NEG_QUARTER_TURN);

	always_comb begin
		case (meta_s2.op)
			OP_MAG, OP_ANGLE: begin
				if (a_s2[31]) begin
					x0 = -ax;
					y0 = -bx;
					z0 = b_s2[31] ? NEG_HALF_TURN : HALF_TURN;
				end else begin
					x0 = ax;
					y0 = bx;
					z0 = '0;
				end
			end
			default: begin
				y0 = '0;
				if (far) begin
					x0 = -ax;
					z0 = $signed({{(ZW-32){zf[31]}}, zf});
				end else begin
					x0 = ax;
					z0 = $signed({{(ZW-32){zr[31]}}, zr});
				end
			end
		endcase
	end

	// gain and angle products
	assign vsel  = (meta_sc[CORDIC_STEPS].op == OP_POLAR_Y) ? y_sc[CORDIC_STEPS]
	                                                        : x_sc[CORDIC_STEPS];
	assign vabs  = vsel[DW-1] ? $unsigned(-vsel) : $unsigned(vsel);
	assign hi_d  = HIW'(vabs[DW-1:16]) * HIW'(INV_GAIN);
	assign lo_d  = LOW'(vabs[15:0]) * LOW'(INV_GAIN);
	assign ang_d = z_sc[CORDIC_STEPS] * $signed({1'b0, TWO_PI_Q28});

	// rounding of both magnitudes
	assign gsum = (HIW+1)'(hi_s4) + (HIW+1)'(lo_s4 >> 16)
	            + ((HIW+1)'(1) << (15 + GUARD_BITS));
	assign aabs = ang_s4[AW-1] ? $unsigned(-ang_s4) : $unsigned(ang_s4);
	assign asum = aabs + (AW'(1) << (ANG_SHIFT - 1));
	assign ashr = asum >> ANG_SHIFT;

	assign sres = rneg_s5 ? -$signed({1'b0, rmag_s5}) : $signed({1'b0, rmag_s5});

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_sc[0] <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
		end else if (advance) begin
			vld_s1    <= s_axis_tvalid;
			vld_s2    <= vld_s1;
			vld_sc[0] <= vld_s2;
			vld_s4    <= vld_sc[CORDIC_STEPS];
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
		end
	end

	// setup stages
	always_ff @(posedge clk) begin
		if (advance) begin
			meta_s1    <= meta_in;
			a_s1       <= a_in;
			b_s1       <= b_in;
			prod_s1    <= theta_prod;
			meta_s2    <= meta_s1;
			a_s2       <= a_s1;
			b_s2       <= b_s1;
			tmag_s2    <= tsum[FRACTION_BITS +: 32];
			tneg_s2    <= prod_s1[PW-1];
			meta_sc[0] <= meta_s2;
			x_sc[0]    <= x0;
			y_sc[0]    <= y0;
			z_sc[0]    <= z0;
		end
	end

	// micro-rotations
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		pcc_cordic_stage #(
			.SHIFT(k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (advance),
			.in_valid (vld_sc[k]),
			.in_meta  (meta_sc[k]),
			.in_x     (x_sc[k]),
			.in_y     (y_sc[k]),
			.in_z     (z_sc[k]),
			.out_valid(vld_sc[k+1]),
			.out_meta (meta_sc[k+1]),
			.out_x    (x_sc[k+1]),
			.out_y    (y_sc[k+1]),
			.out_z    (z_sc[k+1])
		);
	end

	// gain removal, turns to radians, clamp
	always_ff @(posedge clk) begin
		if (advance) begin
			meta_s4 <= meta_sc[CORDIC_STEPS];
			vneg_s4 <= vsel[DW-1];
			hi_s4   <= hi_d;
			lo_s4   <= lo_d;
			ang_s4  <= ang_d;

			meta_s5 <= meta_s4;
			if (meta_s4.op == OP_ANGLE) begin
				rneg_s5 <= ang_s4[AW-1];
				rmag_s5 <= meta_s4.origin ? '0 : RW'(ashr);
			end else begin
				rneg_s5 <= vneg_s4;
				rmag_s5 <= gsum[HIW:16+GUARD_BITS];
			end

			if (!rneg_s5 && (rmag_s5 > POS_LIM)) begin
				res_s6 <= RES_MAX;
				sat_s6 <= 1'b1;
			end else if (rneg_s5 && (rmag_s5 > NEG_LIM)) begin
				res_s6 <= RES_MIN;
				sat_s6 <= 1'b1;
			end else begin
				res_s6 <= sres[31:0];
				sat_s6 <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid   = vld_s6;
	assign m_axis_tdata    = res_s6;
	assign m_axis_tuser[0] = sat_s6;

endmodule

/* rtl/core/pcc_cordic_stage.sv */
// one registered cordic micro-rotation, shared by vectoring and rotation modes
module pcc_cordic_stage
	import pcc_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  pcc_meta_t            in_meta,
	input  logic signed [DW-1:0] in_x,
	input  logic signed [DW-1:0] in_y,
	input  logic signed [ZW-1:0] in_z,
	output logic                 out_valid,
	output pcc_meta_t            out_meta,
	output logic signed [DW-1:0] out_x,
	output logic signed [DW-1:0] out_y,
	output logic signed [ZW-1:0] out_z
);

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [ZW-1:0] da;
	logic                 vectoring;
	logic                 cw;

	// shifted terms, floor rounding
	assign dx = in_y >>> SHIFT;
	assign dy = in_x >>> SHIFT;
	assign da = $signed({{(ZW-32){1'b0}}, ATAN_TURNS[SHIFT]});

	// vectoring drives y to zero, rotation drives z to zero
	assign vectoring = (in_meta.op == OP_MAG) || (in_meta.op == OP_ANGLE);
	assign cw        = vectoring ? ~in_y[DW-1] : in_z[ZW-1];

	// valid tracks the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	// rotate one step
	always_ff @(posedge clk) begin
		if (en) begin
			out_meta <= in_meta;
			if (cw) begin
				out_x <= in_x + dx;
				out_y <= in_y - dy;
				out_z <= in_z + da;
			end else begin
				out_x <= in_x - dx;
				out_y <= in_y + dy;
				out_z <= in_z - da;
			end
		end
	end

endmodule
